// ----- hdl/sd128_pkg.sv -----
// ---------------------------------------------------------------------------
// sd128_pkg: shared definitions for the signed 128-bit divider
// Holds the fixed payload width of the channel halves.
// ---------------------------------------------------------------------------
package sd128_pkg;

   // Width of one half of a channel operand or result.
   localparam int HalfBits = 64;

endpackage

// ----- hdl/sd128_if.sv -----
// ---------------------------------------------------------------------------
// sd128_req_if / sd128_rsp_if: valid/ready channels of the divider
// Request carries the dividend and divisor, response carries the results.
// ---------------------------------------------------------------------------
interface sd128_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sd128_pkg::HalfBits-1:0] dividend_high;
   logic        [sd128_pkg::HalfBits-1:0] dividend_low;
   logic signed [sd128_pkg::HalfBits-1:0] divisor_high;
   logic        [sd128_pkg::HalfBits-1:0] divisor_low;

   modport source (output valid, dividend_high, dividend_low, divisor_high,
                   divisor_low, input ready);
   modport sink (input valid, dividend_high, dividend_low, divisor_high,
                 divisor_low, output ready);
endinterface

interface sd128_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sd128_pkg::HalfBits-1:0] quotient_high;
   logic        [sd128_pkg::HalfBits-1:0] quotient_low;
   logic signed [sd128_pkg::HalfBits-1:0] remainder_high;
   logic        [sd128_pkg::HalfBits-1:0] remainder_low;
   logic                                  divide_by_zero;

   modport source (output valid, quotient_high, quotient_low, remainder_high,
                   remainder_low, divide_by_zero, input ready);
   modport sink (input valid, quotient_high, quotient_low, remainder_high,
                 remainder_low, divide_by_zero, output ready);
endinterface

// ----- hdl/sd128_cell.sv -----
// ---------------------------------------------------------------------------
// sd128_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// where it fits and records the quotient bit; registers everything onward.
// ---------------------------------------------------------------------------
module sd128_cell #(
   parameter int W   = 128,
   parameter int Bit = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  logic         valid_in,
   input  logic [W-1:0] rem_in,
   input  logic [W-1:0] num_in,
   input  logic [W-1:0] den_in,
   input  logic [W-1:0] quo_in,
   input  logic         qneg_in,
   input  logic         rneg_in,
   input  logic         zero_in,
   output logic         valid_out,
   output logic [W-1:0] rem_out,
   output logic [W-1:0] num_out,
   output logic [W-1:0] den_out,
   output logic [W-1:0] quo_out,
   output logic         qneg_out,
   output logic         rneg_out,
   output logic         zero_out
);

   logic [W:0]   shifted;
   logic [W:0]   diff;
   logic [W-1:0] rem_in_next;
   logic [W-1:0] quo_in_next;
   logic         valid_ff;
   logic [W-1:0] rem_ff, num_ff, den_ff, quo_ff;
   logic         qneg_ff, rneg_ff, zero_ff;

   // Trial subtraction of the divisor from the shifted remainder.
   always_comb begin
      shifted     = {rem_in, num_in[Bit]};
      diff        = shifted - {1'b0, den_in};
      quo_in_next = quo_in;
      if (!diff[W]) begin
         rem_in_next      = diff[W-1:0];
         quo_in_next[Bit] = 1'b1;
      end else begin
         rem_in_next = shifted[W-1:0];
      end
   end

   // Control bit of the stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // Payload of the stage.
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in_next;
         num_ff  <= num_in;
         den_ff  <= den_in;
         quo_ff  <= quo_in_next;
         qneg_ff <= qneg_in;
         rneg_ff <= rneg_in;
         zero_ff <= zero_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign num_out   = num_ff;
   assign den_out   = den_ff;
   assign quo_out   = quo_ff;
   assign qneg_out  = qneg_ff;
   assign rneg_out  = rneg_ff;
   assign zero_out  = zero_ff;

endmodule

// ----- hdl/signed_divide_128.sv -----
// ---------------------------------------------------------------------------
// signed_divide_128: pipelined truncating signed division of 128-bit values
// Channel | Dir | Payload
// req     | in  | dividend_high/low, divisor_high/low
// rsp     | out | quotient_high/low, remainder_high/low, divide_by_zero
// One word is taken per cycle while the response is not stalled; an input
// stage forms magnitudes, one cell per quotient bit follows, an output stage
// fixes signs. Reset is synchronous and clears only the valid bits. A stalled
// response freezes the whole row, so req_ready then follows rsp_ready.
// ---------------------------------------------------------------------------
module signed_divide_128 #(
   parameter int WORD_BITS = 128
) (
   input  logic clock,
   input  logic reset,
   sd128_req_if.sink   req,
   sd128_rsp_if.source rsp
);

   localparam int H = sd128_pkg::HalfBits;
   // Operand width, held to the range that the halves can carry.
   localparam int W = (WORD_BITS < H) ? H : ((WORD_BITS > 2*H) ? 2*H : WORD_BITS);

   logic [2*H-1:0] num_raw, den_raw;
   logic [W-1:0]   num_w, den_w;
   logic           enable;

   logic [W-1:0] rem_c [0:W];
   logic [W-1:0] num_c [0:W];
   logic [W-1:0] den_c [0:W];
   logic [W-1:0] quo_c [0:W];
   logic         val_c [0:W];
   logic         qn_c  [0:W];
   logic         rn_c  [0:W];
   logic         zr_c  [0:W];

   logic         out_valid_ff;
   logic [W-1:0] q_fix, r_fix;
   logic [2*H-1:0] q_ff, q_in, r_ff, r_in;
   logic         zero_ff;

   // The row advances whenever the output slot is free or being taken.
   assign enable    = !out_valid_ff || rsp.ready;
   assign req.ready = enable;

   // Input stage: truncate to the word width and take magnitudes.
   assign num_raw = {req.dividend_high, req.dividend_low};
   assign den_raw = {req.divisor_high, req.divisor_low};
   assign num_w   = num_raw[W-1:0];
   assign den_w   = den_raw[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         val_c[0] <= 1'b0;
      end else if (enable) begin
         val_c[0] <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_c[0] <= num_w[W-1] ? (~num_w + 1'b1) : num_w;
         den_c[0] <= den_w[W-1] ? (~den_w + 1'b1) : den_w;
         qn_c[0]  <= num_w[W-1] ^ den_w[W-1];
         rn_c[0]  <= num_w[W-1];
         zr_c[0]  <= (den_w == '0);
      end
   end

   assign rem_c[0] = '0;
   assign quo_c[0] = '0;

   // Row of division cells, most significant quotient bit first.
   for (genvar g = 0; g < W; g++) begin : g_cell
      logic [W-1:0] rem_s;
      sd128_cell #(.W(W), .Bit(W-1-g)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_in(val_c[g]), .rem_in(rem_c[g]), .num_in(num_c[g]),
         .den_in(den_c[g]), .quo_in(quo_c[g]), .qneg_in(qn_c[g]),
         .rneg_in(rn_c[g]), .zero_in(zr_c[g]),
         .valid_out(val_c[g+1]), .rem_out(rem_s), .num_out(num_c[g+1]),
         .den_out(den_c[g+1]), .quo_out(quo_c[g+1]), .qneg_out(qn_c[g+1]),
         .rneg_out(rn_c[g+1]), .zero_out(zr_c[g+1])
      );
      assign rem_c[g+1] = rem_s;
   end

   // Output stage: restore signs, sign-extend, force zero on a zero divisor.
   always_comb begin
      q_fix = qn_c[W] ? (~quo_c[W] + 1'b1) : quo_c[W];
      r_fix = rn_c[W] ? (~rem_c[W] + 1'b1) : rem_c[W];
      q_in  = (2*H)'($signed(q_fix));
      r_in  = (2*H)'($signed(r_fix));
      if (zr_c[W]) begin
         q_in = '0;
         r_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= val_c[W];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         q_ff    <= q_in;
         r_ff    <= r_in;
         zero_ff <= zr_c[W];
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.quotient_high  = q_ff[2*H-1:H];
   assign rsp.quotient_low   = q_ff[H-1:0];
   assign rsp.remainder_high = r_ff[2*H-1:H];
   assign rsp.remainder_low  = r_ff[H-1:0];
   assign rsp.divide_by_zero = zero_ff;

endmodule

// ----- tb/signed_divide_128_tb.sv -----
// ---------------------------------------------------------------------------
// signed_divide_128_tb: self-checking bench for the signed 128-bit divider
// Directed edge cases, then random operands under varied idling on both
// channels. Each result word is compared with a predicted quotient and
// remainder held in order of issue.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module signed_divide_128_tb;

   localparam int WordBits   = 128;
   localparam int CycleLimit = 400000;
   localparam int StallHold  = 400;

   typedef struct packed {
      logic [127:0] quotient;
      logic [127:0] remainder;
      logic         divide_by_zero;
   } div_result_type;

   logic clock;
   logic reset;
   int   cycle_count;
   int   error_count;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   hold_off;

   div_result_type expected_results[$];

   sd128_req_if req ();
   sd128_rsp_if rsp ();

   signed_divide_128 #(.WORD_BITS(WordBits)) DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   // Free-running clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Cycle counter with a run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Predicts truncating division with the remainder signed as the dividend.
   function automatic div_result_type predict_division(logic [127:0] dividend,
                                                       logic [127:0] divisor);
      div_result_type res;
      logic [127:0] num_mag;
      logic [127:0] den_mag;
      logic [127:0] part;
      logic [127:0] quo;
      logic         num_neg;
      logic         den_neg;
      res = '0;
      if (divisor == '0) begin
         res.divide_by_zero = 1'b1;
         return res;
      end
      num_neg = dividend[127];
      den_neg = divisor[127];
      num_mag = num_neg ? -dividend : dividend;
      den_mag = den_neg ? -divisor : divisor;
      part = '0;
      quo  = '0;
      for (int i = 127; i >= 0; i--) begin
         part = {part[126:0], num_mag[i]};
         if (part >= den_mag) begin
            part = part - den_mag;
            quo[i] = 1'b1;
         end
      end
      res.quotient  = (num_neg != den_neg) ? -quo : quo;
      res.remainder = num_neg ? -part : part;
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [127:0] got,
                                  logic [127:0] want);
      $display("mismatch %s at cycle %0d: got %h want %h", field, cycle_count,
               got, want);
      error_count++;
   endtask

   // Offers one word and waits until it is taken; valid stays high after.
   task automatic send_division(logic [127:0] dividend, logic [127:0] divisor);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.dividend_high <= dividend[127:64];
      req.dividend_low  <= dividend[63:0];
      req.divisor_high  <= divisor[127:64];
      req.divisor_low   <= divisor[63:0];
      expected_results.push_back(predict_division(dividend, divisor));
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Receiver readiness, with idling and an optional long hold-off.
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // Checks each accepted result word against the oldest prediction.
   always @(posedge clock) begin
      div_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected word", 128'(0), 128'(0));
         end else begin
            want = expected_results.pop_front();
            if ({rsp.quotient_high, rsp.quotient_low} != want.quotient)
               report_mismatch("quotient", {rsp.quotient_high, rsp.quotient_low},
                               want.quotient);
            if ({rsp.remainder_high, rsp.remainder_low} != want.remainder)
               report_mismatch("remainder", {rsp.remainder_high, rsp.remainder_low},
                               want.remainder);
            if (rsp.divide_by_zero != want.divide_by_zero)
               report_mismatch("divide_by_zero", 128'(rsp.divide_by_zero),
                               128'(want.divide_by_zero));
         end
      end
   end

   function automatic logic [127:0] random_wide();
      logic [127:0] v;
      v = {$urandom, $urandom, $urandom, $urandom};
      // Shorten some operands so small quotients and remainders appear.
      case ($urandom_range(3))
         0: v = $signed(v) >>> $urandom_range(127);
         1: v = v >> $urandom_range(127);
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_edge_cases();
      logic [127:0] most_neg;
      logic [127:0] most_pos;
      most_neg = {1'b1, 127'b0};
      most_pos = {1'b0, {127{1'b1}}};
      send_division(128'd100, 128'd7);
      send_division(-128'sd100, 128'd7);
      send_division(128'd100, -128'sd7);
      send_division(-128'sd100, -128'sd7);
      send_division(128'd5, 128'd0);
      send_division(most_neg, 128'd0);
      send_division(most_neg, -128'sd1);
      send_division(most_neg, 128'd1);
      send_division(most_neg, most_neg);
      send_division(most_pos, most_neg);
      send_division(most_neg, most_pos);
      send_division(most_pos, 128'd1);
      send_division(most_pos, -128'sd1);
      send_division(128'd0, most_neg);
      send_division(128'd0, 128'd3);
      send_division(128'd3, 128'd10);
      send_division({128{1'b1}}, {128{1'b1}});
      send_division({64'h0, {64{1'b1}}}, {64'h1, 64'h0});
      send_division({{64{1'b1}}, 64'h0}, 128'd3);
   endtask

   task automatic test_random(int count);
      logic [127:0] divisor;
      for (int i = 0; i < count; i++) begin
         divisor = random_wide();
         if ($urandom_range(19) == 0) divisor = '0;
         send_division(random_wide(), divisor);
      end
   endtask

   // Receiver holds off while the sender keeps offering words.
   task automatic test_back_pressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (StallHold) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(60);
      join
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (WordBits + 10) @(posedge clock);
   endtask

   initial begin
      cycle_count   = 0;
      error_count   = 0;
      hold_off      = 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 49;
      reset         = 1'b1;
      req.valid         = 1'b0;
      req.dividend_high = '0;
      req.dividend_low  = '0;
      req.divisor_high  = '0;
      req.divisor_low   = '0;
      rsp.ready         = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_cases();
      test_random(150);
      send_idle_pct = 49;
      recv_idle_pct = 16;
      test_random(150);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_back_pressure();
      test_random(190);
      drain();
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
